// ===== rtl/min_max_block_decimator_unit_assert.svh =====
// Assertion macros used by the group queue of the min/max block decimator.
// Each macro takes a label, the clock, the active-low reset, its condition operands and a message.
`ifndef MIN_MAX_BLOCK_DECIMATOR_UNIT_ASSERT_SVH
`define MIN_MAX_BLOCK_DECIMATOR_UNIT_ASSERT_SVH

// The condition holds at every clock edge outside reset.
`define MMBD_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error(msg);

// The antecedent implies the consequent in the same cycle.
`define MMBD_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the next cycle.
`define MMBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mmbd_pkg.sv =====
`default_nettype none

package mmbd_pkg;

    // Width of the block width register.
    localparam int unsigned CFG_BITS = 16;

    // Block width after reset.
    localparam logic [CFG_BITS-1:0] BLOCK_WIDTH_RESET = 16'd2;

    // Control part of one result group handed from the tracker to the queue.
    typedef struct packed {
        logic two_beats;  // group holds two beats, else one
        logic eod;        // group closes the data set
    } t_grp_ctl;

endpackage

`default_nettype wire

// ===== rtl/min_max_block_decimator_unit.sv =====
// Min/max block decimator. Samples (x, y) arrive one beat at a time and are
// grouped into blocks of i_cfg_block_width samples (zero acts as one). For
// each block the first minimum and first maximum of y are kept and sent out
// as two result beats in the order they occurred; when both are the same
// sample, that sample goes first and the block's last sample second. A beat
// with end_of_data closes a short block the same way, except that a block of
// a single sample yields that sample alone; the block state then restarts.
// o_run_last flags the last result beat caused by an input beat, and
// o_stream_last the final beat of a data set. The tracker takes one input
// beat per cycle while the queue has a free group slot; results wait in a
// two-group queue, so input keeps flowing while a finished block drains.
// With the output always ready, the rate is one input beat per cycle for
// widths of two or more; at width one the single output port, carrying two
// beats per input, sets a slower pace. Writes to the width register are
// accepted every cycle and should be made while the block is idle.

`default_nettype none

module min_max_block_decimator_unit #(
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write channel.
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [mmbd_pkg::CFG_BITS-1:0]       i_cfg_block_width,
    // Sample input channel.
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_x_sample,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_y_sample,
    input  wire logic                                i_end_of_data,
    // Result output channel.
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]            o_x_out,
    output logic signed [SAMPLE_BITS-1:0]            o_y_out,
    output logic                                     o_run_last,
    output logic                                     o_stream_last
);

    logic [mmbd_pkg::CFG_BITS-1:0] r_block_width;
    logic                          take;
    logic                          push;
    logic                          room;
    mmbd_pkg::t_grp_ctl            grp_ctl;
    logic signed [SAMPLE_BITS-1:0] grp_x0, grp_y0, grp_x1, grp_y1;

    // The register accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_width <= mmbd_pkg::BLOCK_WIDTH_RESET;
        end else if (i_cfg_valid) begin
            r_block_width <= i_cfg_block_width;
        end
    end

    // A sample beat is taken whenever the queue has a free group slot, so a
    // block that closes always has somewhere to put its results.
    assign o_in_ready = room;
    assign take       = i_in_valid && room;

    mmbd_track #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_block_width (r_block_width),
        .i_take        (take),
        .i_x           (i_x_sample),
        .i_y           (i_y_sample),
        .i_eod         (i_end_of_data),
        .o_push        (push),
        .o_ctl         (grp_ctl),
        .o_x0          (grp_x0),
        .o_y0          (grp_y0),
        .o_x1          (grp_x1),
        .o_y1          (grp_y1)
    );

    mmbd_outq #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_outq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_ctl         (grp_ctl),
        .i_x0          (grp_x0),
        .i_y0          (grp_y0),
        .i_x1          (grp_x1),
        .i_y1          (grp_y1),
        .o_room        (room),
        .o_valid       (o_out_valid),
        .i_ready       (i_out_ready),
        .o_x           (o_x_out),
        .o_y           (o_y_out),
        .o_run_last    (o_run_last),
        .o_stream_last (o_stream_last)
    );

endmodule

`default_nettype wire

// ===== rtl/mmbd_track.sv =====
`default_nettype none

module mmbd_track #(
    parameter int unsigned SAMPLE_BITS = 32,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [mmbd_pkg::CFG_BITS-1:0]       i_block_width,
    input  wire logic                                i_take,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_x,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_y,
    input  wire logic                                i_eod,
    output logic                                     o_push,
    output mmbd_pkg::t_grp_ctl                       o_ctl,
    output logic signed [SAMPLE_BITS-1:0]            o_x0,
    output logic signed [SAMPLE_BITS-1:0]            o_y0,
    output logic signed [SAMPLE_BITS-1:0]            o_x1,
    output logic signed [SAMPLE_BITS-1:0]            o_y1
);

    localparam int unsigned CMP_BITS =
        (COUNT_BITS > mmbd_pkg::CFG_BITS) ? COUNT_BITS : mmbd_pkg::CFG_BITS;

    logic [COUNT_BITS-1:0]         r_fill, n_fill;
    logic signed [SAMPLE_BITS-1:0] r_low_y, r_low_x, r_high_y, r_high_x;
    logic signed [SAMPLE_BITS-1:0] n_low_y, n_low_x, n_high_y, n_high_x;
    logic [COUNT_BITS-1:0]         r_low_pos, r_high_pos, n_low_pos, n_high_pos;

    logic [COUNT_BITS-1:0]         count;
    logic [mmbd_pkg::CFG_BITS-1:0] width;
    logic                          first;
    logic                          full;
    logic                          single;

    assign first = (r_fill == '0);
    assign count = r_fill + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign width = (i_block_width == '0) ? {{(mmbd_pkg::CFG_BITS-1){1'b0}}, 1'b1}
                                         : i_block_width;
    assign full  = (CMP_BITS'(count) >= CMP_BITS'(width)) || (count == '1);
    assign single = !full && i_eod && (count == {{(COUNT_BITS-1){1'b0}}, 1'b1});

    // Running minimum and maximum; the first sample of a block seeds both.
    always_comb begin
        n_low_y    = r_low_y;
        n_low_x    = r_low_x;
        n_low_pos  = r_low_pos;
        n_high_y   = r_high_y;
        n_high_x   = r_high_x;
        n_high_pos = r_high_pos;
        if (first) begin
            n_low_y    = i_y;
            n_low_x    = i_x;
            n_low_pos  = '0;
            n_high_y   = i_y;
            n_high_x   = i_x;
            n_high_pos = '0;
        end else begin
            if (i_y < r_low_y) begin
                n_low_y   = i_y;
                n_low_x   = i_x;
                n_low_pos = r_fill;
            end
            if (r_high_y < i_y) begin
                n_high_y   = i_y;
                n_high_x   = i_x;
                n_high_pos = r_fill;
            end
        end
        n_fill = (full || i_eod) ? '0 : count;
    end

    // Order the kept samples by position. When minimum and maximum are the
    // same sample, the second beat is the sample that closes the block.
    always_comb begin
        o_push          = i_take && (full || i_eod);
        o_ctl.two_beats = !single;
        o_ctl.eod       = i_eod;
        o_x1            = i_x;
        o_y1            = i_y;
        if (single) begin
            o_x0 = i_x;
            o_y0 = i_y;
        end else if (n_low_pos == n_high_pos) begin
            o_x0 = n_low_x;
            o_y0 = n_low_y;
        end else if (n_low_pos < n_high_pos) begin
            o_x0 = n_low_x;
            o_y0 = n_low_y;
            o_x1 = n_high_x;
            o_y1 = n_high_y;
        end else begin
            o_x0 = n_high_x;
            o_y0 = n_high_y;
            o_x1 = n_low_x;
            o_y1 = n_low_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_take) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_low_y    <= n_low_y;
            r_low_x    <= n_low_x;
            r_low_pos  <= n_low_pos;
            r_high_y   <= n_high_y;
            r_high_x   <= n_high_x;
            r_high_pos <= n_high_pos;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/mmbd_outq.sv =====
`default_nettype none

`include "min_max_block_decimator_unit_assert.svh"

module mmbd_outq #(
    parameter int unsigned SAMPLE_BITS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire mmbd_pkg::t_grp_ctl            i_ctl,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x0,
    input  wire logic signed [SAMPLE_BITS-1:0] i_y0,
    input  wire logic signed [SAMPLE_BITS-1:0] i_x1,
    input  wire logic signed [SAMPLE_BITS-1:0] i_y1,
    output logic                               o_room,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_x,
    output logic signed [SAMPLE_BITS-1:0]      o_y,
    output logic                               o_run_last,
    output logic                               o_stream_last
);

    // Two group slots, each holding one or two result beats.
    mmbd_pkg::t_grp_ctl            r_ctl [2];
    logic signed [SAMPLE_BITS-1:0] r_x0 [2];
    logic signed [SAMPLE_BITS-1:0] r_y0 [2];
    logic signed [SAMPLE_BITS-1:0] r_x1 [2];
    logic signed [SAMPLE_BITS-1:0] r_y1 [2];

    logic       r_wp, r_rp, r_sub;
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    mmbd_pkg::t_grp_ctl head;

    assign head    = r_ctl[r_rp];
    assign o_valid = (r_cnt != 2'd0);
    assign o_room  = (r_cnt != 2'd2);
    assign pop     = o_valid && i_ready && (r_sub || !head.two_beats);

    assign o_x           = r_sub ? r_x1[r_rp] : r_x0[r_rp];
    assign o_y           = r_sub ? r_y1[r_rp] : r_y0[r_rp];
    assign o_run_last    = r_sub || !head.two_beats;
    assign o_stream_last = head.eod && (r_sub || !head.two_beats);

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_sub <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp  <= !r_rp;
                r_sub <= 1'b0;
            end else if (o_valid && i_ready) begin
                r_sub <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ctl[r_wp] <= i_ctl;
            r_x0[r_wp]  <= i_x0;
            r_y0[r_wp]  <= i_y0;
            r_x1[r_wp]  <= i_x1;
            r_y1[r_wp]  <= i_y1;
        end
    end

    `MMBD_ASSERT_IMPLIES(a_no_overflow, i_clk, i_rst_n, i_push, r_cnt != 2'd2, "group queue overflow")
    `MMBD_ASSERT_IMPLIES(a_sub_two, i_clk, i_rst_n, r_sub, o_valid && head.two_beats, "second beat of a one-beat group")
    `MMBD_ASSERT_NEXT(a_pop_drains, i_clk, i_rst_n, pop && !i_push, r_cnt == $past(r_cnt) - 2'd1, "group count did not drop on pop")
    `MMBD_ASSERT_ALWAYS(a_cnt_range, i_clk, i_rst_n, r_cnt != 2'd3, "group count out of range")

endmodule

`default_nettype wire
